// File: design/ffba_pkg.sv
// shared types and codes for the first-fit block allocator
package ffba_pkg;

  // item actions
  localparam logic [1:0] ACT_ALLOC   = 2'd0;
  localparam logic [1:0] ACT_RELEASE = 2'd1;
  localparam logic [1:0] ACT_CLEAR   = 2'd2;

  // result status codes
  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_BAD_OFS  = 2'd2;

  // fixed field widths of the stream payloads
  localparam int unsigned REQ_W  = 13;
  localparam int unsigned OFS_W  = 12;
  localparam int unsigned FREE_W = 13;

  // outcome of fitting a request into one free block
  typedef struct packed {
    logic exact;
    logic split;
  } fit_t;

endpackage

// File: design/first_fit_block_allocator.sv
// top level: first-fit allocator sequencer over the header store
//
// Input stream s_axis carries one request transaction: allocate, release or
// clear. Output stream m_axis returns exactly one result per request with
// status, payload offset and the free byte count after the request.
// Requests are handled one at a time; s_axis_tready is high only while the
// sequencer is idle. A finished result sits in the output register, so the
// next request can be taken while the receiver stalls; a further result
// waits in the sequencer until the output register empties.
// An ignored release, an unused action or an allocate refused on the free
// count goes straight from acceptance to the result. A release reads its
// block header and then, unless the block ends at the arena end, each header
// past the block (absorbed free blocks and the used block that ends the merge).
// Allocate reads the header of each visited block and, for a free block, each
// header past it that it absorbs, then writes its header back, plus the remainder
// header for a split; the walk stops after ARENA_BYTES / MIN_SPLIT + 1 blocks.
// Every header visit is one registered read of the header store.
// After reset, and after a clear request, a clearing pass writes every
// header entry, one per cycle, with s_axis_tready low; the result of a clear
// is sent once the pass ends.
module first_fit_block_allocator #(
  parameter int unsigned ARENA_BYTES  = 4096,
  parameter int unsigned HEADER_BYTES = 16,
  parameter int unsigned MIN_SPLIT    = 17
) (
  input  logic        clk,
  input  logic        rst,
  // action [1:0], request_bytes [14:2], release_offset [26:15]
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  // status [1:0], payload_offset [13:2], free_bytes [26:14]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata
);

  localparam int unsigned AW    = $clog2(ARENA_BYTES);
  localparam int unsigned MW    = AW + 2;
  localparam int unsigned WW    = ((AW + 1 > ffba_pkg::REQ_W) ? AW + 1 : ffba_pkg::REQ_W) + 2;
  localparam int unsigned LIMIT = ARENA_BYTES / MIN_SPLIT + 1;
  localparam int unsigned CNTW  = $clog2(LIMIT + 1);

  typedef enum logic [12:0] {
    S_CLEAR    = 13'b0000000000001,
    S_IDLE     = 13'b0000000000010,
    S_A_RD     = 13'b0000000000100,
    S_A_HDR    = 13'b0000000001000,
    S_A_ABS_RD = 13'b0000000010000,
    S_A_ABS    = 13'b0000000100000,
    S_A_FIT    = 13'b0000001000000,
    S_A_SPLIT  = 13'b0000010000000,
    S_R_RD     = 13'b0000100000000,
    S_R_HDR    = 13'b0001000000000,
    S_R_ABS_RD = 13'b0010000000000,
    S_R_ABS    = 13'b0100000000000,
    S_OUT      = 13'b1000000000000
  } state_t;

  state_t state, state_next;

  logic [AW-1:0]               blk, blk_next;
  logic [AW:0]                 fend, fend_next;
  logic [AW-1:0]               split, split_next;
  logic [AW:0]                 size, size_next;
  logic [CNTW-1:0]             cnt, cnt_next;
  logic [ffba_pkg::REQ_W-1:0]  req, req_next;
  logic [AW:0]                 freec, freec_next;
  logic [1:0]                  status, status_next;
  logic [ffba_pkg::OFS_W-1:0]  payload, payload_next;
  logic [AW-1:0]               clr_addr, clr_addr_next;
  logic                        clr_reply, clr_reply_next;

  logic                        out_valid;
  logic [31:0]                 out_data;

  logic                        mem_we;
  logic [AW-1:0]               mem_waddr, mem_raddr;
  logic [MW-1:0]               mem_wdata, mem_rdata;
  logic                        rd_used;
  logic [AW:0]                 rd_next;

  ffba_pkg::fit_t              fit;
  logic [AW-1:0]               fit_split;

  logic [1:0]                  in_action;
  logic [ffba_pkg::REQ_W-1:0]  in_req;
  logic [ffba_pkg::OFS_W-1:0]  in_ofs;
  logic [WW-1:0]               ofs_w, sum_w, pay_w;
  logic [AW:0]                 e_blk, e_fend, nb;
  logic                        last_step;

  // end of a block as read from its header, stale entries read as arena end
  function automatic logic [AW:0] end_of(input logic [AW-1:0] pos, input logic [AW:0] n);
    if (n <= (AW+1)'(pos) || n > (AW+1)'(ARENA_BYTES)) begin
      end_of = (AW+1)'(ARENA_BYTES);
    end else begin
      end_of = n;
    end
  endfunction

  assign in_action = s_axis_tdata[1:0];
  assign in_req    = s_axis_tdata[14:2];
  assign in_ofs    = s_axis_tdata[26:15];

  assign rd_used = mem_rdata[MW-1];
  assign rd_next = mem_rdata[AW:0];

  ffba_hdr_mem #(
    .DEPTH (ARENA_BYTES),
    .WIDTH (MW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ffba_fit_unit #(
    .ARENA_BYTES  (ARENA_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .MIN_SPLIT    (MIN_SPLIT)
  ) u_fit (
    .blk       (blk),
    .blk_end   (fend),
    .req       (req),
    .fit       (fit),
    .split_pos (fit_split)
  );

  // read address follows the walk position
  assign mem_raddr = (state == S_A_ABS_RD || state == S_R_ABS_RD) ? fend[AW-1:0] : blk;

  assign e_blk     = end_of(blk, rd_next);
  assign e_fend    = end_of(fend[AW-1:0], rd_next);
  assign nb        = (fend >= (AW+1)'(ARENA_BYTES)) ? '0 : fend;
  assign last_step = (cnt == CNTW'(LIMIT - 1));
  assign ofs_w     = WW'(in_ofs);
  assign sum_w     = WW'(freec) + WW'(size);
  assign pay_w     = WW'(blk) + WW'(HEADER_BYTES);

  assign s_axis_tready = (state == S_IDLE);

  // sequencer
  always_comb begin
    state_next     = state;
    blk_next       = blk;
    fend_next      = fend;
    split_next     = split;
    size_next      = size;
    cnt_next       = cnt;
    req_next       = req;
    freec_next     = freec;
    status_next    = status;
    payload_next   = payload;
    clr_addr_next  = clr_addr;
    clr_reply_next = clr_reply;
    mem_we         = 1'b0;
    mem_waddr      = blk;
    mem_wdata      = {1'b0, fend};
    unique case (state)
      S_CLEAR: begin
        mem_we        = 1'b1;
        mem_waddr     = clr_addr;
        mem_wdata     = {1'b0, (AW+1)'(ARENA_BYTES)};
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == AW'(ARENA_BYTES - 1)) begin
          state_next     = clr_reply ? S_OUT : S_IDLE;
          clr_reply_next = 1'b0;
        end
      end
      S_IDLE: begin
        if (s_axis_tvalid) begin
          req_next     = in_req;
          payload_next = '0;
          status_next  = ffba_pkg::ST_DONE;
          unique case (in_action)
            ffba_pkg::ACT_ALLOC: begin
              blk_next = '0;
              cnt_next = '0;
              if (WW'(freec) >= WW'(in_req) + WW'(HEADER_BYTES)) begin
                state_next = S_A_RD;
              end else begin
                status_next = ffba_pkg::ST_NO_SPACE;
                state_next  = S_OUT;
              end
            end
            ffba_pkg::ACT_RELEASE: begin
              if (ofs_w < WW'(HEADER_BYTES) || ofs_w >= WW'(ARENA_BYTES)) begin
                status_next = ffba_pkg::ST_BAD_OFS;
                state_next  = S_OUT;
              end else begin
                blk_next   = AW'(ofs_w - WW'(HEADER_BYTES));
                state_next = S_R_RD;
              end
            end
            ffba_pkg::ACT_CLEAR: begin
              freec_next     = (AW+1)'(ARENA_BYTES);
              clr_addr_next  = '0;
              clr_reply_next = 1'b1;
              state_next     = S_CLEAR;
            end
            default: begin
              state_next = S_OUT;
            end
          endcase
        end
      end
      S_A_RD: begin
        state_next = S_A_HDR;
      end
      S_A_HDR: begin
        fend_next = e_blk;
        if (rd_used) begin
          cnt_next = cnt + 1'b1;
          blk_next = (e_blk >= (AW+1)'(ARENA_BYTES)) ? '0 : e_blk[AW-1:0];
          if (last_step) begin
            status_next = ffba_pkg::ST_NO_SPACE;
            state_next  = S_OUT;
          end else begin
            state_next = S_A_RD;
          end
        end else if (e_blk < (AW+1)'(ARENA_BYTES)) begin
          state_next = S_A_ABS_RD;
        end else begin
          state_next = S_A_FIT;
        end
      end
      S_A_ABS_RD: begin
        state_next = S_A_ABS;
      end
      S_A_ABS: begin
        if (rd_used) begin
          state_next = S_A_FIT;
        end else begin
          fend_next = e_fend;
          state_next = (e_fend < (AW+1)'(ARENA_BYTES)) ? S_A_ABS_RD : S_A_FIT;
        end
      end
      S_A_FIT: begin
        // header of the merged block, or of the split remainder
        mem_we = 1'b1;
        priority if (fit.exact) begin
          mem_wdata    = {1'b1, fend};
          freec_next   = freec - fend + (AW+1)'(blk);
          payload_next = pay_w[ffba_pkg::OFS_W-1:0];
          state_next   = S_OUT;
        end else if (fit.split) begin
          mem_waddr  = fit_split;
          split_next = fit_split;
          state_next = S_A_SPLIT;
        end else begin
          cnt_next = cnt + 1'b1;
          blk_next = nb[AW-1:0];
          if (last_step) begin
            status_next = ffba_pkg::ST_NO_SPACE;
            state_next  = S_OUT;
          end else begin
            state_next = S_A_RD;
          end
        end
      end
      S_A_SPLIT: begin
        mem_we       = 1'b1;
        mem_wdata    = {1'b1, (AW+1)'(split)};
        freec_next   = freec - ((AW+1)'(split) - (AW+1)'(blk));
        payload_next = pay_w[ffba_pkg::OFS_W-1:0];
        state_next   = S_OUT;
      end
      S_R_RD: begin
        state_next = S_R_HDR;
      end
      S_R_HDR: begin
        fend_next = e_blk;
        size_next = e_blk - (AW+1)'(blk);
        state_next = (e_blk < (AW+1)'(ARENA_BYTES)) ? S_R_ABS_RD : S_R_ABS;
      end
      S_R_ABS_RD: begin
        state_next = S_R_ABS;
      end
      S_R_ABS: begin
        // the merge ends at a used block or the arena end
        if (fend >= (AW+1)'(ARENA_BYTES) || rd_used) begin
          mem_we     = 1'b1;
          mem_wdata  = {1'b0, fend};
          freec_next = (sum_w > WW'(ARENA_BYTES)) ? (AW+1)'(ARENA_BYTES) : sum_w[AW:0];
          state_next = S_OUT;
        end else begin
          fend_next  = e_fend;
          state_next = (e_fend < (AW+1)'(ARENA_BYTES)) ? S_R_ABS_RD : S_R_ABS;
        end
      end
      S_OUT: begin
        if (!out_valid || m_axis_tready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      clr_reply <= 1'b0;
      freec     <= (AW+1)'(ARENA_BYTES);
    end else begin
      state     <= state_next;
      clr_addr  <= clr_addr_next;
      clr_reply <= clr_reply_next;
      freec     <= freec_next;
    end
  end

  // walk payload registers
  always_ff @(posedge clk) begin
    blk     <= blk_next;
    fend    <= fend_next;
    split   <= split_next;
    size    <= size_next;
    cnt     <= cnt_next;
    req     <= req_next;
    status  <= status_next;
    payload <= payload_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && (!out_valid || m_axis_tready)) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!out_valid || m_axis_tready)) begin
      out_data <= {5'd0, freec, payload, status};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

endmodule

// File: design/ffba_hdr_mem.sv
// block header store: one write port, one registered read port
module ffba_hdr_mem #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned WIDTH = 14
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: design/ffba_fit_unit.sv
// compare unit: does a request fit a free block whole or by split
module ffba_fit_unit #(
  parameter int unsigned ARENA_BYTES  = 4096,
  parameter int unsigned HEADER_BYTES = 16,
  parameter int unsigned MIN_SPLIT    = 17
) (
  input  logic [$clog2(ARENA_BYTES)-1:0] blk,
  input  logic [$clog2(ARENA_BYTES):0]   blk_end,
  input  logic [ffba_pkg::REQ_W-1:0]     req,
  output ffba_pkg::fit_t                 fit,
  output logic [$clog2(ARENA_BYTES)-1:0] split_pos
);

  localparam int unsigned AW = $clog2(ARENA_BYTES);
  localparam int unsigned WW = ((AW + 1 > ffba_pkg::REQ_W) ? AW + 1 : ffba_pkg::REQ_W) + 2;

  logic [WW-1:0] need;
  logic [WW-1:0] end_w;

  // payload end of a block taken at exactly the request size
  assign need  = WW'(blk) + WW'(HEADER_BYTES) + WW'(req);
  assign end_w = WW'(blk_end);

  assign fit.exact = (end_w == need);
  assign fit.split = (end_w >= need + WW'(MIN_SPLIT));
  assign split_pos = need[AW-1:0];

endmodule

// File: design/ffba_checker.sv
// port-level checks for the first-fit block allocator, bound to the top level
module ffba_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [31:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // the clearing pass follows reset
  a_clear: assert property (@(posedge clk) rst |=> !s_axis_tready)
    else $error("request taken during clearing pass");

  // no unused status code is sent
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
    else $error("unknown status");

  // failed or ignored requests carry no offset
  a_offset: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[1:0] != ffba_pkg::ST_DONE |-> m_axis_tdata[13:2] == 12'd0)
    else $error("offset on a failed request");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// File: bench/first_fit_block_allocator_tb.sv
// testbench for the first-fit block allocator: directed table, random traffic, predictor
`timescale 1ns / 1ps

module first_fit_block_allocator_tb;

  localparam int unsigned ARENA  = 4096;
  localparam int unsigned HDR    = 16;
  localparam int unsigned MSPLIT = 17;
  localparam int unsigned WALK_MAX = ARENA / MSPLIT + 1;
  localparam int unsigned REQ_W  = ffba_pkg::REQ_W;
  localparam int unsigned OFS_W  = ffba_pkg::OFS_W;
  localparam int unsigned FREE_W = ffba_pkg::FREE_W;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]        action;
    logic [REQ_W-1:0]  req;
    logic [OFS_W-1:0]  ofs;
  } request_t;

  // laid out as on m_axis_tdata: status in the lowest bits
  typedef struct packed {
    logic [FREE_W-1:0] free;
    logic [OFS_W-1:0]  payload;
    logic [1:0]        status;
  } outcome_t;

  // directed row: request plus optional typed expectation
  typedef struct {
    request_t  rq;
    bit        has_exp;
    outcome_t  exp;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  first_fit_block_allocator uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow header store
  int unsigned hdr_next [ARENA];
  bit          hdr_used [ARENA];
  int unsigned free_cnt;

  outcome_t pending_results[$];
  outcome_t pinned_results[$];
  bit       pinned_valid[$];
  int       fail_count = 0;
  bit       stim_done = 1'b0;
  bit       hold_off = 1'b0;
  int       live_allocs[$];

  function automatic void arena_clear();
    for (int i = 0; i < ARENA; i++) begin
      hdr_next[i] = ARENA;
      hdr_used[i] = 1'b0;
    end
    free_cnt = ARENA;
  endfunction

  function automatic int unsigned block_end(int unsigned b);
    int unsigned n;
    n = hdr_next[b];
    if (n <= b || n > ARENA) return ARENA;
    return n;
  endfunction

  function automatic void merge_forward(int unsigned b);
    int unsigned f;
    f = block_end(b);
    while (f < ARENA && !hdr_used[f]) f = block_end(f);
    hdr_next[b] = f;
  endfunction

  // compute the allocator's answer and update the shadow store
  function automatic outcome_t allocator_predict(request_t rq);
    outcome_t o;
    int unsigned b, n, sp, sz;
    int d;
    o = '0;
    o.status = ffba_pkg::ST_DONE;
    case (rq.action)
      ffba_pkg::ACT_ALLOC: begin
        o.status = ffba_pkg::ST_NO_SPACE;
        if (free_cnt >= rq.req + HDR) begin
          b = 0;
          for (int i = 0; i < WALK_MAX; i++) begin
            if (!hdr_used[b]) begin
              merge_forward(b);
              d = int'(block_end(b)) - int'(b) - int'(HDR);
              if (d == int'(rq.req)) begin
                hdr_used[b] = 1'b1;
                free_cnt -= block_end(b) - b;
                o.payload = OFS_W'(b + HDR);
                o.status = ffba_pkg::ST_DONE;
                break;
              end else if (d >= int'(rq.req) + int'(MSPLIT)) begin
                sp = b + HDR + rq.req;
                hdr_next[sp] = hdr_next[b];
                hdr_used[sp] = 1'b0;
                hdr_next[b] = sp;
                hdr_used[b] = 1'b1;
                free_cnt -= sp - b;
                o.payload = OFS_W'(b + HDR);
                o.status = ffba_pkg::ST_DONE;
                break;
              end
            end
            n = block_end(b);
            b = (n >= ARENA) ? 0 : n;
          end
        end
      end
      ffba_pkg::ACT_RELEASE: begin
        if (rq.ofs < HDR || rq.ofs >= ARENA) begin
          o.status = ffba_pkg::ST_BAD_OFS;
        end else begin
          b = rq.ofs - HDR;
          hdr_used[b] = 1'b0;
          sz = block_end(b) - b;
          merge_forward(b);
          free_cnt += sz;
          if (free_cnt > ARENA) free_cnt = ARENA;
        end
      end
      ffba_pkg::ACT_CLEAR: arena_clear();
      default: ;
    endcase
    o.free = FREE_W'(free_cnt);
    return o;
  endfunction

  function automatic request_t mk(logic [1:0] a, int unsigned r, int unsigned p);
    request_t q;
    q.action = a;
    q.req = REQ_W'(r);
    q.ofs = OFS_W'(p);
    return q;
  endfunction

  function automatic outcome_t res(logic [1:0] s, int unsigned p, int unsigned f);
    outcome_t o;
    o.status = s;
    o.payload = OFS_W'(p);
    o.free = FREE_W'(f);
    return o;
  endfunction

  // one transaction on the input side, with a random gap first
  task automatic send_request(request_t rq, bit has_exp, outcome_t exp);
    int gap;
    outcome_t pred;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
        : ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'd0, rq.ofs, rq.req, rq.action};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pred = allocator_predict(rq);
    pending_results.push_back(pred);
    pinned_valid.push_back(has_exp);
    pinned_results.push_back(exp);
    if (rq.action == ffba_pkg::ACT_ALLOC && pred.status == ffba_pkg::ST_DONE)
      live_allocs.push_back(pred.payload);
    if (rq.action == ffba_pkg::ACT_CLEAR) live_allocs.delete();
  endtask

  function automatic int unsigned pick_size();
    int k;
    k = $urandom_range(0, 19);
    if (k < 12) return $urandom_range(0, 64);
    if (k < 17) return $urandom_range(65, 600);
    if (k < 19) return $urandom_range(600, 4096);
    return $urandom_range(4097, 8191);
  endfunction

  // output side: random stalls and compare against predictions
  always @(posedge clk) begin
    outcome_t got, exp, pin;
    bit pv;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = outcome_t'(m_axis_tdata[26:0]);
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: %h", m_axis_tdata);
        fail_count++;
      end else begin
        exp = pending_results.pop_front();
        pin = pinned_results.pop_front();
        pv = pinned_valid.pop_front();
        if (pv && pin != exp) begin
          $error("table entry disagrees with predictor: table %h predictor %h", pin, exp);
          fail_count++;
        end
        if (got.status != exp.status) begin
          $error("status expected %0d actual %0d", exp.status, got.status);
          fail_count++;
        end
        if (got.payload != exp.payload) begin
          $error("payload_offset expected %0d actual %0d", exp.payload, got.payload);
          fail_count++;
        end
        if (got.free != exp.free) begin
          $error("free_bytes expected %0d actual %0d", exp.free, got.free);
          fail_count++;
        end
      end
    end
  end

  // receiver readiness: mostly ready, random short and rare long stalls
  initial begin
    int stall;
    m_axis_tready <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        m_axis_tready <= 1'b0;
      end else begin
        stall = $urandom_range(0, 99);
        if (stall < 60) begin
          m_axis_tready <= 1'b1;
        end else if (stall < 97) begin
          m_axis_tready <= 1'b0;
          repeat ($urandom_range(1, 4)) @(posedge clk);
          m_axis_tready <= 1'b1;
        end else begin
          m_axis_tready <= 1'b0;
          repeat ($urandom_range(20, 80)) @(posedge clk);
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  // long receiver hold-off so the block backs up its input
  initial begin
    @(negedge rst);
    repeat (30000) @(posedge clk);
    hold_off = 1'b1;
    repeat (600) @(posedge clk);
    hold_off = 1'b0;
  end

  // stimulus
  initial begin
    row_t rows[$];
    request_t rq;
    int k, idx;
    arena_clear();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed table: exp typed in where it is obvious
    rows.push_back('{mk(ACT_UNUSED, 8191, 4095), 1, res(ffba_pkg::ST_DONE, 0, 4096)});
    rows.push_back('{mk(ffba_pkg::ACT_RELEASE, 0, 0), 1, res(ffba_pkg::ST_BAD_OFS, 0, 4096)});
    rows.push_back('{mk(ffba_pkg::ACT_RELEASE, 0, 15), 1, res(ffba_pkg::ST_BAD_OFS, 0, 4096)});
    rows.push_back('{mk(ffba_pkg::ACT_ALLOC, 8191, 0), 1, res(ffba_pkg::ST_NO_SPACE, 0, 4096)});
    rows.push_back('{mk(ffba_pkg::ACT_ALLOC, 4081, 0), 1, res(ffba_pkg::ST_NO_SPACE, 0, 4096)});
    rows.push_back('{mk(ffba_pkg::ACT_ALLOC, 4080, 0), 1, res(ffba_pkg::ST_DONE, 16, 0)});
    rows.push_back('{mk(ffba_pkg::ACT_ALLOC, 0, 0), 1, res(ffba_pkg::ST_NO_SPACE, 0, 0)});
    rows.push_back('{mk(ffba_pkg::ACT_RELEASE, 0, 16), 1, res(ffba_pkg::ST_DONE, 0, 4096)});
    rows.push_back('{mk(ffba_pkg::ACT_RELEASE, 0, 16), 1, res(ffba_pkg::ST_DONE, 0, 4096)});
    rows.push_back('{mk(ffba_pkg::ACT_ALLOC, 0, 0), 0, '0});
    rows.push_back('{mk(ffba_pkg::ACT_ALLOC, 100, 0), 0, '0});
    rows.push_back('{mk(ffba_pkg::ACT_ALLOC, 3900, 0), 0, '0});
    rows.push_back('{mk(ffba_pkg::ACT_RELEASE, 0, 4095), 0, '0});
    rows.push_back('{mk(ffba_pkg::ACT_RELEASE, 0, 16), 0, '0});
    rows.push_back('{mk(ffba_pkg::ACT_RELEASE, 0, 33), 0, '0});
    rows.push_back('{mk(ffba_pkg::ACT_ALLOC, 1, 0), 0, '0});
    rows.push_back('{mk(ffba_pkg::ACT_CLEAR, 0, 0), 1, res(ffba_pkg::ST_DONE, 0, 4096)});
    // request too big to split and not an exact fit, then the smallest request
    rows.push_back('{mk(ffba_pkg::ACT_ALLOC, 4064, 0), 0, '0});
    rows.push_back('{mk(ffba_pkg::ACT_ALLOC, 0, 0), 0, '0});
    rows.push_back('{mk(ffba_pkg::ACT_ALLOC, 16, 0), 0, '0});
    rows.push_back('{mk(ffba_pkg::ACT_RELEASE, 0, 16), 0, '0});
    rows.push_back('{mk(ffba_pkg::ACT_ALLOC, 4000, 0), 0, '0});
    rows.push_back('{mk(ffba_pkg::ACT_CLEAR, 0, 0), 1, res(ffba_pkg::ST_DONE, 0, 4096)});
    foreach (rows[i]) send_request(rows[i].rq, rows[i].has_exp, rows[i].exp);

    // random part: mostly alloc/release of live blocks, some noise
    for (int n = 0; n < 1500; n++) begin
      k = $urandom_range(0, 99);
      if (k < 50) begin
        rq = mk(ffba_pkg::ACT_ALLOC, pick_size(), $urandom_range(0, 4095));
      end else if (k < 88 && live_allocs.size() > 0) begin
        idx = $urandom_range(0, live_allocs.size() - 1);
        rq = mk(ffba_pkg::ACT_RELEASE, $urandom_range(0, 8191), live_allocs[idx]);
        live_allocs.delete(idx);
      end else if (k < 95) begin
        rq = mk(ffba_pkg::ACT_RELEASE, $urandom_range(0, 8191), $urandom_range(0, 4095));
      end else if (k < 97) begin
        rq = mk(ACT_UNUSED, $urandom_range(0, 8191), $urandom_range(0, 4095));
      end else begin
        rq = mk(ffba_pkg::ACT_CLEAR, $urandom_range(0, 8191), $urandom_range(0, 4095));
      end
      send_request(rq, 1'b0, '0);
    end
    s_axis_tvalid <= 1'b0;
    stim_done = 1'b1;
  end

  // end of run
  initial begin
    wait (stim_done);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20000000;
    $display("tb: failure");
    $finish;
  end

endmodule

// File: files.f
design/ffba_pkg.sv
design/ffba_hdr_mem.sv
design/ffba_fit_unit.sv
design/first_fit_block_allocator.sv
design/ffba_checker.sv
bench/first_fit_block_allocator_tb.sv
